/* sv/swl_pkg.sv */
// Shared types, constants and helper functions for the sliding window linearity block.
`default_nettype none
package swl_pkg;

    localparam int DEF_WINDOW      = 5;
    localparam int DEF_COORD_WIDTH = 18;
    localparam int RED_MAX         = 20;
    localparam int Q_BITS          = 18;
    localparam int FRAC            = 15;
    localparam int ONE_Q15         = 32768;

    localparam logic [1:0] CRD_X = 2'd0;
    localparam logic [1:0] CRD_Y = 2'd1;
    localparam logic [1:0] CRD_Z = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAC,
        ST_FIN,
        ST_ROOT,
        ST_RWAIT,
        ST_DEN,
        ST_DIV,
        ST_DWAIT,
        ST_EMIT,
        ST_UPD
    } state_t;

    typedef enum logic [2:0] {
        K_XX,
        K_YY,
        K_ZZ,
        K_XY,
        K_XZ,
        K_YZ
    } kind_t;

    function automatic logic [1:0] kind_a(kind_t k);
        logic [1:0] c;
        unique case (k)
            K_YY, K_YZ: c = CRD_Y;
            K_ZZ:       c = CRD_Z;
            default:    c = CRD_X;
        endcase
        return c;
    endfunction

    function automatic logic [1:0] kind_b(kind_t k);
        logic [1:0] c;
        unique case (k)
            K_XX:       c = CRD_X;
            K_YY, K_XY: c = CRD_Y;
            default:    c = CRD_Z;
        endcase
        return c;
    endfunction

    function automatic kind_t plane_kind(logic [1:0] p);
        kind_t k;
        unique case (p)
            2'd0:    k = K_XY;
            2'd1:    k = K_XZ;
            default: k = K_YZ;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

/* sv/swl_mul.sv */
// Shared registered signed multiplier.
`default_nettype none
module swl_mul #(
    parameter int OW = 27
) (
    input  logic                   clk,
    input  logic                   go,
    input  logic signed [OW-1:0]   a,
    input  logic signed [OW-1:0]   b,
    output logic signed [2*OW-1:0] p
);
    logic signed [2*OW-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            p_reg <= a * b;
        end
    end

    assign p = p_reg;
endmodule
`default_nettype wire

/* sv/swl_isqrt.sv */
// Iterative integer square root, two radicand bits per cycle.
`default_nettype none
module swl_isqrt #(
    parameter int VW = 52
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [VW-1:0]     val,
    output logic              done,
    output logic [VW/2-1:0]   root
);
    logic [VW-1:0] v_reg;
    logic [VW-1:0] r_reg;
    logic [VW-1:0] b_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [VW-1:0] trial;

    assign trial = r_reg + b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && b_reg[0])
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg <= val;
            r_reg <= '0;
            b_reg <= VW'(1) << (VW - 2);
        end
        else if (busy_reg)
        begin
            if (v_reg >= trial)
            begin
                v_reg <= v_reg - trial;
                r_reg <= (r_reg >> 1) + b_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            b_reg <= b_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = r_reg[VW/2-1:0];
endmodule
`default_nettype wire

/* sv/swl_div.sv */
// Restoring divider with rounding numerator and Q1.15 saturation.
`default_nettype none
module swl_div #(
    parameter int DENW = 52,
    parameter int NUMW = 71,
    parameter int QW   = 18
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [NUMW-1:0] num,
    input  logic [DENW-1:0] den,
    output logic            done,
    output logic [15:0]     quo
);
    import swl_pkg::*;

    localparam int CW = $clog2(QW + 1);

    logic [NUMW-1:0] rem_reg;
    logic [NUMW-1:0] dsh_reg;
    logic [QW-1:0]   q_reg;
    logic [CW-1:0]   cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic            sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(QW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            dsh_reg <= NUMW'(den) << (QW - 1);
            sat_reg <= num >= (NUMW'(den) << QW);
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_reg <= rem_reg - dsh_reg;
                q_reg   <= {q_reg[QW-2:0], 1'b1};
            end
            else
            begin
                q_reg <= {q_reg[QW-2:0], 1'b0};
            end
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign done = done_reg;
    assign quo  = (sat_reg || (q_reg > QW'(ONE_Q15))) ? 16'(ONE_Q15) : q_reg[15:0];
endmodule
`default_nettype wire

/* sv/sliding_window_linearity.sv */
// Top level: windowed |Pearson r| of a 3D track in XY, XZ and YZ planes.
//
//  channel | handshake          | word
//  in      | in_valid/in_ready  | point_x, point_y, point_z, point_valid, track_end
//  out     | out_valid/out_ready| lin_xy, lin_xz, lin_yz, degenerate_mask, short_track, is_last
//
// Word with no result: IDLE, then UPD. Short-track word: IDLE, EMIT (waits for output), UPD.
// Word with a result: the shared multiplier sweep, the iterative square root and the iterative
// divider (skipped per degenerate plane), then EMIT waits for output and UPD follows.
// in_ready is high only when idle; a finished result waits in the output register.
// Reset clears the window and the point count.
`default_nettype none
module sliding_window_linearity #(
    parameter int WINDOW      = swl_pkg::DEF_WINDOW,
    parameter int COORD_WIDTH = swl_pkg::DEF_COORD_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_y,
    input  logic signed [COORD_WIDTH-1:0] point_z,
    input  logic                          point_valid,
    input  logic                          track_end,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [15:0]                   lin_xy,
    output logic [15:0]                   lin_xz,
    output logic [15:0]                   lin_yz,
    output logic [2:0]                    degenerate_mask,
    output logic                          short_track,
    output logic                          is_last
);
    import swl_pkg::*;

    localparam int RW      = (COORD_WIDTH > RED_MAX) ? RED_MAX : COORD_WIDTH;
    localparam int RSH     = COORD_WIDTH - RW;
    localparam int DW      = RW + 1;
    localparam int CLW     = $clog2(WINDOW + 1);
    localparam int SW      = DW + CLW;
    localparam int VW      = 2 * (RW + CLW + 2);
    localparam int HW      = VW / 2;
    localparam int MOW     = HW + 1;
    localparam int NW      = VW + Q_BITS + 1;
    localparam int IW      = $clog2(WINDOW);
    localparam int CNTW    = $clog2(WINDOW + 3);
    localparam int MIN_TRK = WINDOW + 1;
    localparam int CMAX    = WINDOW + 2;

    state_t state_reg, state_next;

    logic [2:0][RW-1:0]   win_reg [WINDOW];
    logic [CNTW-1:0]      cnt_reg;
    logic [IW-1:0]        idx_reg;
    kind_t                kind_reg;
    logic [1:0]           crd_reg;
    logic [1:0]           pl_reg;
    logic                 mtag_vld_reg;
    logic                 mtag_fin_reg;
    kind_t                mtag_kind_reg;
    logic                 out_valid_reg;

    logic [RW-1:0]        px_reg, py_reg, pz_reg;
    logic                 pv_reg;
    logic                 last_reg;
    logic                 short_reg;
    logic signed [SW-1:0] s_reg [3];
    logic signed [VW-1:0] q_reg [6];
    logic [HW-1:0]        root_reg [3];
    logic [15:0]          lin_reg [3];
    logic [2:0]           mask_reg;
    logic [15:0]          o_lin_reg [3];
    logic [2:0]           o_mask_reg;
    logic                 o_short_reg;
    logic                 o_last_reg;

    logic signed [DW-1:0]    dev [3];
    logic                    mul_go, acc_go, sq_go, div_go, out_load;
    logic signed [MOW-1:0]   mul_a, mul_b;
    logic signed [2*MOW-1:0] mul_p;
    logic signed [VW-1:0]    prod;
    logic                    sq_done, div_done;
    logic [HW-1:0]           sq_root;
    logic [15:0]             div_q;
    kind_t                   pk;
    logic [1:0]              pa, pb;
    logic                    degen;
    logic [VW-1:0]           den;
    logic [VW-1:0]           a_abs;
    logic [NW-1:0]           num;
    logic                    need, short_now;
    logic [CNTW-1:0]         cnt_after;
    logic [COORD_WIDTH-1:0]  ox, oy, oz;

    assign ox = {~point_x[COORD_WIDTH-1], point_x[COORD_WIDTH-2:0]};
    assign oy = {~point_y[COORD_WIDTH-1], point_y[COORD_WIDTH-2:0]};
    assign oz = {~point_z[COORD_WIDTH-1], point_z[COORD_WIDTH-2:0]};

    assign need      = point_valid && (cnt_reg >= CNTW'(MIN_TRK));
    assign cnt_after = (point_valid && (cnt_reg < CNTW'(CMAX))) ? cnt_reg + CNTW'(1) : cnt_reg;
    assign short_now = track_end && !need && (cnt_after < CNTW'(MIN_TRK));

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            dev[c] = signed'({1'b0, win_reg[idx_reg][c]}) - signed'({1'b0, win_reg[0][c]});
        end
    end

    assign pk    = plane_kind(pl_reg);
    assign pa    = kind_a(pk);
    assign pb    = kind_b(pk);
    assign prod  = mul_p[VW-1:0];
    assign den   = mul_p[VW-1:0];
    assign degen = q_reg[{1'b0, pa}][VW-1] || (q_reg[{1'b0, pa}] == '0) ||
                   q_reg[{1'b0, pb}][VW-1] || (q_reg[{1'b0, pb}] == '0);
    assign a_abs = q_reg[pk][VW-1] ? VW'(-q_reg[pk]) : VW'(q_reg[pk]);
    assign num   = (NW'(a_abs) << FRAC) + NW'(den >> 1);

    swl_mul #(.OW(MOW)) u_mul (
        .clk (clk),
        .go  (mul_go),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    swl_isqrt #(.VW(VW)) u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_go),
        .val   (VW'(q_reg[{1'b0, crd_reg}])),
        .done  (sq_done),
        .root  (sq_root)
    );

    swl_div #(.DENW(VW), .NUMW(NW), .QW(Q_BITS)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_go),
        .num   (num),
        .den   (den),
        .done  (div_done),
        .quo   (div_q)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    priority if (need)
                        state_next = ST_MAC;
                    else if (short_now)
                        state_next = ST_EMIT;
                    else
                        state_next = ST_UPD;
                end
            end
            ST_MAC:
            begin
                if ((idx_reg == IW'(WINDOW - 1)) && (kind_reg == K_YZ))
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (kind_reg == K_YZ)
                    state_next = ST_ROOT;
            end
            ST_ROOT:
                state_next = ST_RWAIT;
            ST_RWAIT:
            begin
                if (sq_done)
                    state_next = (crd_reg == CRD_Z) ? ST_DEN : ST_ROOT;
            end
            ST_DEN:
                state_next = ST_DIV;
            ST_DIV:
            begin
                if (degen)
                    state_next = (pl_reg == 2'd2) ? ST_EMIT : ST_DEN;
                else
                    state_next = ST_DWAIT;
            end
            ST_DWAIT:
            begin
                if (div_done)
                    state_next = (pl_reg == 2'd2) ? ST_EMIT : ST_DEN;
            end
            ST_EMIT:
            begin
                if (out_load)
                    state_next = ST_UPD;
            end
            ST_UPD:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        mul_go   = 1'b0;
        acc_go   = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        sq_go    = 1'b0;
        div_go   = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:
                in_ready = 1'b1;
            ST_MAC:
            begin
                mul_go = 1'b1;
                acc_go = 1'b1;
                mul_a  = MOW'(dev[kind_a(kind_reg)]);
                mul_b  = MOW'(dev[kind_b(kind_reg)]);
            end
            ST_FIN:
            begin
                mul_go = 1'b1;
                acc_go = 1'b1;
                mul_a  = MOW'(s_reg[kind_a(kind_reg)]);
                mul_b  = MOW'(s_reg[kind_b(kind_reg)]);
            end
            ST_ROOT:
                sq_go = 1'b1;
            ST_DEN:
            begin
                mul_go = 1'b1;
                mul_a  = signed'({1'b0, root_reg[pa]});
                mul_b  = signed'({1'b0, root_reg[pb]});
            end
            ST_DIV:
                div_go = !degen;
            ST_EMIT:
                out_load = !out_valid_reg || out_ready;
            ST_RWAIT, ST_DWAIT, ST_UPD:
                ;
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            kind_reg      <= K_XX;
            crd_reg       <= CRD_X;
            pl_reg        <= '0;
            mtag_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < WINDOW; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            mtag_vld_reg <= acc_go;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    idx_reg  <= IW'(1);
                    kind_reg <= K_XX;
                    crd_reg  <= CRD_X;
                    pl_reg   <= '0;
                end
                ST_MAC:
                begin
                    if (kind_reg == K_YZ)
                    begin
                        kind_reg <= K_XX;
                        idx_reg  <= idx_reg + IW'(1);
                    end
                    else
                    begin
                        kind_reg <= kind_t'(kind_reg + 3'd1);
                    end
                end
                ST_FIN:
                begin
                    kind_reg <= (kind_reg == K_YZ) ? K_XX : kind_t'(kind_reg + 3'd1);
                end
                ST_RWAIT:
                begin
                    if (sq_done)
                        crd_reg <= crd_reg + 2'd1;
                end
                ST_DIV:
                begin
                    if (degen)
                        pl_reg <= pl_reg + 2'd1;
                end
                ST_DWAIT:
                begin
                    if (div_done)
                        pl_reg <= pl_reg + 2'd1;
                end
                ST_UPD:
                begin
                    if (last_reg)
                    begin
                        cnt_reg <= '0;
                        for (int i = 0; i < WINDOW; i++)
                        begin
                            win_reg[i] <= '0;
                        end
                    end
                    else if (pv_reg)
                    begin
                        if (cnt_reg < CNTW'(CMAX))
                            cnt_reg <= cnt_reg + CNTW'(1);
                        for (int i = 0; i < WINDOW - 1; i++)
                        begin
                            win_reg[i] <= win_reg[i + 1];
                        end
                        win_reg[WINDOW - 1] <= {pz_reg, py_reg, px_reg};
                    end
                end
                ST_ROOT, ST_DEN, ST_EMIT:
                    ;
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        mtag_fin_reg  <= (state_reg == ST_FIN);
        mtag_kind_reg <= kind_reg;

        if (mtag_vld_reg)
        begin
            if (mtag_fin_reg)
                q_reg[mtag_kind_reg] <= q_reg[mtag_kind_reg] * VW'(WINDOW) - prod;
            else
                q_reg[mtag_kind_reg] <= q_reg[mtag_kind_reg] + prod;
        end

        if (state_reg == ST_IDLE && in_valid)
        begin
            px_reg    <= RW'(ox >> RSH);
            py_reg    <= RW'(oy >> RSH);
            pz_reg    <= RW'(oz >> RSH);
            pv_reg    <= point_valid;
            last_reg  <= track_end;
            short_reg <= short_now;
            mask_reg  <= '0;
            for (int c = 0; c < 3; c++)
            begin
                s_reg[c]   <= '0;
                lin_reg[c] <= '0;
            end
            for (int k = 0; k < 6; k++)
            begin
                q_reg[k] <= '0;
            end
        end

        if (state_reg == ST_MAC && kind_reg == K_XX)
        begin
            for (int c = 0; c < 3; c++)
            begin
                s_reg[c] <= s_reg[c] + SW'(dev[c]);
            end
        end

        if (state_reg == ST_RWAIT && sq_done)
            root_reg[crd_reg] <= sq_root;

        if (state_reg == ST_DIV && degen)
        begin
            lin_reg[pl_reg]  <= '0;
            mask_reg[pl_reg] <= 1'b1;
        end

        if (state_reg == ST_DWAIT && div_done)
            lin_reg[pl_reg] <= div_q;

        if (out_load)
        begin
            for (int c = 0; c < 3; c++)
            begin
                o_lin_reg[c] <= lin_reg[c];
            end
            o_mask_reg  <= mask_reg;
            o_short_reg <= short_reg;
            o_last_reg  <= last_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign lin_xy          = o_lin_reg[0];
    assign lin_xz          = o_lin_reg[1];
    assign lin_yz          = o_lin_reg[2];
    assign degenerate_mask = o_mask_reg;
    assign short_track     = o_short_reg;
    assign is_last         = o_last_reg;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNTW'(CMAX))
        else $error("point count above saturation");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPD && last_reg) |=> (cnt_reg == '0))
        else $error("track end did not clear count");

    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DWAIT))
        else $error("divider done outside wait");

    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg)
        else $error("result not presented after load");
`endif
endmodule
`default_nettype wire

/* tb/sliding_window_linearity_test.sv */
// Testbench for sliding_window_linearity: random tracks checked against a windowed correlation predictor.
`timescale 1ns / 1ps

class lin_scoreboard;
    typedef struct packed {
        logic [15:0] xy;
        logic [15:0] xz;
        logic [15:0] yz;
        logic [2:0]  mask;
        logic        short_trk;
        logic        last;
    } lin_word_t;

    lin_word_t    pending[$];
    logic [17:0]  win[5][3];
    int unsigned  count;
    int           errors;

    function new();
        clear_track();
        errors = 0;
    endfunction

    function void clear_track();
        for (int i = 0; i < 5; i++)
            for (int c = 0; c < 3; c++)
                win[i][c] = '0;
        count = 0;
    endfunction

    function longint unsigned root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function bit plane(int a, int b, output logic [15:0] val);
        longint sa, sb, saa, sbb, sab, da, db, am, bm, cm;
        longint unsigned aa, den, q;
        sa = 0; sb = 0; saa = 0; sbb = 0; sab = 0;
        for (int i = 0; i < 5; i++)
        begin
            da = longint'(win[i][a]) - longint'(win[0][a]);
            db = longint'(win[i][b]) - longint'(win[0][b]);
            sa += da; sb += db;
            saa += da * da; sbb += db * db; sab += da * db;
        end
        am = 5 * sab - sa * sb;
        bm = 5 * saa - sa * sa;
        cm = 5 * sbb - sb * sb;
        if (bm <= 0 || cm <= 0)
        begin
            val = '0;
            return 1'b1;
        end
        aa = am < 0 ? -am : am;
        den = root_floor(bm) * root_floor(cm);
        q = (aa * 32768 + den / 2) / den;
        if (q > 32768)
            q = 32768;
        val = q[15:0];
        return 1'b0;
    endfunction

    function void note_point(logic [17:0] x, logic [17:0] y, logic [17:0] z, bit pv, bit te);
        lin_word_t w;
        bit got;
        got = 0;
        w = '0;
        if (pv)
        begin
            if (count >= 6)
            begin
                w.mask[0] = plane(0, 1, w.xy);
                w.mask[1] = plane(0, 2, w.xz);
                w.mask[2] = plane(1, 2, w.yz);
                w.last = te;
                got = 1;
            end
            for (int i = 0; i < 4; i++)
                win[i] = win[i + 1];
            win[4][0] = x ^ 18'h20000;
            win[4][1] = y ^ 18'h20000;
            win[4][2] = z ^ 18'h20000;
            if (count < 7)
                count++;
        end
        if (te)
        begin
            if (!got && count < 6)
            begin
                w = '0;
                w.short_trk = 1;
                w.last = 1;
                got = 1;
            end
            clear_track();
        end
        if (got)
            pending = {pending, w};
    endfunction

    function void check_result(lin_word_t a);
        lin_word_t e;
        if (pending.size() == 0)
        begin
            $error("unexpected result word");
            errors++;
            return;
        end
        e = pending.pop_front();
        if (a.xy !== e.xy) begin $error("lin_xy exp %0d got %0d", e.xy, a.xy); errors++; end
        if (a.xz !== e.xz) begin $error("lin_xz exp %0d got %0d", e.xz, a.xz); errors++; end
        if (a.yz !== e.yz) begin $error("lin_yz exp %0d got %0d", e.yz, a.yz); errors++; end
        if (a.mask !== e.mask)
        begin
            $error("degenerate_mask exp %0d got %0d", e.mask, a.mask);
            errors++;
        end
        if (a.short_trk !== e.short_trk)
        begin
            $error("short_track exp %0d got %0d", e.short_trk, a.short_trk);
            errors++;
        end
        if (a.last !== e.last)
        begin
            $error("is_last exp %0d got %0d", e.last, a.last);
            errors++;
        end
    endfunction
endclass

module sliding_window_linearity_test;
    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_ready;
    logic signed [17:0] point_x = 0, point_y = 0, point_z = 0;
    logic point_valid = 0, track_end = 0;
    logic out_valid;
    logic out_ready = 0;
    logic [15:0] lin_xy, lin_xz, lin_yz;
    logic [2:0] degenerate_mask;
    logic short_track, is_last;

    lin_scoreboard sb = new();
    bit quiet = 0;
    longint cycles = 0;

    always
    begin
        #1 clk = 1;
        #1 clk = 0;
    end

    sliding_window_linearity u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .point_x(point_x), .point_y(point_y), .point_z(point_z),
        .point_valid(point_valid), .track_end(track_end),
        .out_valid(out_valid), .out_ready(out_ready),
        .lin_xy(lin_xy), .lin_xz(lin_xz), .lin_yz(lin_yz),
        .degenerate_mask(degenerate_mask), .short_track(short_track), .is_last(is_last)
    );

    always @(posedge clk)
    begin
        cycles++;
        if (rst_n && out_valid && out_ready)
            sb.check_result({lin_xy, lin_xz, lin_yz, degenerate_mask, short_track, is_last});
        if (cycles > 2000000)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver stalls in bursts
    initial
    begin
        int n;
        @(negedge clk);
        forever
        begin
            if (!quiet && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 0;
                n = $urandom_range(1, 8);
                repeat (n) @(negedge clk);
            end
            else
            begin
                out_ready <= 1;
                n = $urandom_range(1, 12);
                repeat (n) @(negedge clk);
            end
        end
    end

    task automatic send_point(logic [17:0] x, logic [17:0] y, logic [17:0] z, bit pv, bit te);
        int n;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 0;
            n = $urandom_range(1, 8);
            repeat (n) @(negedge clk);
        end
        in_valid <= 1;
        point_x <= x; point_y <= y; point_z <= z;
        point_valid <= pv; track_end <= te;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_point(x, y, z, pv, te);
        @(negedge clk);
    endtask

    function automatic logic [17:0] rand_coord(int style);
        case (style)
            0: return 18'h1FFFF;
            1: return 18'h20000;
            2: return 18'($urandom_range(0, 15));
            default: return 18'($urandom);
        endcase
    endfunction

    task automatic send_track(int len, bit noisy);
        int st;
        logic [17:0] x, y, z, bx, by, bz, dx, dy, dz;
        st = $urandom_range(0, 3);
        bx = 18'($urandom); by = 18'($urandom); bz = 18'($urandom);
        dx = 18'(int'($urandom_range(0, 2000)) - 1000);
        dy = 18'(int'($urandom_range(0, 2000)) - 1000);
        dz = 18'(int'($urandom_range(0, 2000)) - 1000);
        for (int i = 0; i < len; i++)
        begin
            case (st)
                0: begin x = rand_coord(3); y = rand_coord(3); z = rand_coord(3); end
                1: begin
                    x = 18'(bx + dx * i + $urandom_range(0, 7));
                    y = 18'(by + dy * i + $urandom_range(0, 7));
                    z = 18'(bz + dz * i + $urandom_range(0, 7));
                end
                2: begin x = bx; y = 18'(by + dy * i); z = rand_coord($urandom_range(0, 3)); end
                default: begin
                    x = rand_coord($urandom_range(0, 3));
                    y = rand_coord($urandom_range(0, 3));
                    z = rand_coord($urandom_range(0, 3));
                end
            endcase
            send_point(x, y, z, !(noisy && $urandom_range(0, 5) == 0), i == len - 1);
        end
    endtask

    initial
    begin
        int items;
        int len;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;
        @(negedge clk);
        // directed: empty track, invalid-only, short, exactly six, extremes
        send_point(18'h1FFFF, 18'h20000, 0, 0, 1);
        send_point(0, 0, 0, 1, 1);
        for (int i = 0; i < 3; i++)
            send_point(18'h1FFFF, 18'h20000, 18'h3FFFF, 1, 0);
        send_point(0, 0, 0, 0, 1);
        for (int i = 0; i < 6; i++)
            send_point(18'(i * 100), 18'(i * 50), 18'h20000, 1, i == 5);
        for (int i = 0; i < 8; i++)
            send_point(i[0] ? 18'h1FFFF : 18'h20000, i[1] ? 18'h1FFFF : 18'h20000,
                       18'(i * 3), 1, i == 7);
        items = 20;
        while (items < 950)
        begin
            if (items > 850)
                quiet = 1;
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : $urandom_range(7, 20);
            send_track(len, $urandom_range(0, 3) == 0);
            items += len;
        end
        in_valid <= 0;
        quiet = 1;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
